/* src/psl_pkg.sv */
// Shared types and constants for the page slot lookup table.
// Used by psl_cam and page_slot_lookup_table_unit; no dependencies.
package psl_pkg;

   localparam int TABLE_ENTRIES = 64;

   localparam int FILE_ID_W   = 8;
   localparam int PAGE_W      = 20;
   localparam int KEY_W       = FILE_ID_W + PAGE_W;
   localparam int SLOT_W      = 8;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_FIND   = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_DELETE = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_PRESENT   = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic              fire;
      kind_type          kind;
      logic [KEY_W-1:0]  key;
      logic [SLOT_W-1:0] slot;
   } lookup_req_type;

   typedef struct packed {
      logic              hit;
      logic              full;
      logic [SLOT_W-1:0] slot;
   } lookup_rsp_type;

endpackage

/* src/page_slot_lookup_table_unit.sv */
// Page slot lookup table top level: input register, lookup decision, result register.
// Flow: an accepted request sits in the input register for the parallel key compare;
// its result goes to the result register, which rsp_tready low holds, stalling both.
// Throughput: one transaction per cycle, unless rsp_tready low stalls the pipeline.
// Reset: synchronous; clears the pipeline valids and empties the table at once.
// Depends on psl_pkg and psl_cam.
module page_slot_lookup_table_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [7:0] file_id, [27:8] page_number, [35:28] slot_in, [39:36] zero
   input  logic [psl_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [1:0] kind
   input  logic [psl_pkg::KIND_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] slot_out
   output logic [psl_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [1:0] status
   output logic [psl_pkg::STATUS_W-1:0]     rsp_tuser
);

   logic                          in_valid_ff;
   psl_pkg::kind_type             in_kind_ff;
   logic [psl_pkg::KEY_W-1:0]     in_key_ff;
   logic [psl_pkg::SLOT_W-1:0]    in_slot_ff;

   logic                          out_valid_ff;
   psl_pkg::status_type           out_status_ff;
   logic [psl_pkg::SLOT_W-1:0]    out_slot_ff;

   psl_pkg::status_type           status_in;
   logic [psl_pkg::SLOT_W-1:0]    slot_in;
   logic                          advance;
   logic                          req_fire;

   psl_pkg::lookup_req_type       lookup_req;
   psl_pkg::lookup_rsp_type       lookup_rsp;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff <= psl_pkg::kind_type'(req_tuser);
         in_key_ff  <= {req_tdata[7:0], req_tdata[27:8]};
         in_slot_ff <= req_tdata[35:28];
      end
   end

   assign lookup_req.fire = advance;
   assign lookup_req.kind = in_kind_ff;
   assign lookup_req.key  = in_key_ff;
   assign lookup_req.slot = in_slot_ff;

   psl_cam u_cam (
      .clock      (clock),
      .reset      (reset),
      .lookup_req (lookup_req),
      .lookup_rsp (lookup_rsp)
   );

   always_comb begin
      status_in = psl_pkg::ST_NOT_FOUND;
      slot_in   = '0;
      unique case (in_kind_ff)
         psl_pkg::KIND_FIND: begin
            if (lookup_rsp.hit) begin
               status_in = psl_pkg::ST_OK;
               slot_in   = lookup_rsp.slot;
            end
         end
         psl_pkg::KIND_INSERT: begin
            priority if (lookup_rsp.hit) begin
               status_in = psl_pkg::ST_PRESENT;
            end else if (lookup_rsp.full) begin
               status_in = psl_pkg::ST_FULL;
            end else begin
               status_in = psl_pkg::ST_OK;
            end
         end
         psl_pkg::KIND_DELETE: begin
            if (lookup_rsp.hit) begin
               status_in = psl_pkg::ST_OK;
            end
         end
         default: begin
            status_in = psl_pkg::ST_NOT_FOUND;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_status_ff <= status_in;
         out_slot_ff   <= slot_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_slot_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

/* src/psl_cam.sv */
// Associative entry store: parallel key compare, lowest free entry select,
// insert and delete updates. Depends on psl_pkg.
module psl_cam (
   input  logic                   clock,
   input  logic                   reset,
   input  psl_pkg::lookup_req_type lookup_req,
   output psl_pkg::lookup_rsp_type lookup_rsp
);

   logic [psl_pkg::TABLE_ENTRIES-1:0] valid_ff;
   logic [psl_pkg::TABLE_ENTRIES-1:0] valid_in;
   logic [psl_pkg::KEY_W-1:0]         key_ff  [psl_pkg::TABLE_ENTRIES];
   logic [psl_pkg::SLOT_W-1:0]        slot_ff [psl_pkg::TABLE_ENTRIES];

   logic [psl_pkg::TABLE_ENTRIES-1:0] match_oh;
   logic [psl_pkg::TABLE_ENTRIES-1:0] free_vec;
   logic [psl_pkg::TABLE_ENTRIES-1:0] free_oh;
   logic [psl_pkg::SLOT_W-1:0]        hit_slot;
   logic                              hit;
   logic                              full;
   logic                              insert_en;
   logic                              delete_en;

   always_comb begin
      for (int i = 0; i < psl_pkg::TABLE_ENTRIES; i++) begin
         match_oh[i] = valid_ff[i] && (key_ff[i] == lookup_req.key);
      end
   end

   // at most one hit, so an OR of the gated slots selects it
   always_comb begin
      hit_slot = '0;
      for (int i = 0; i < psl_pkg::TABLE_ENTRIES; i++) begin
         hit_slot = hit_slot | (slot_ff[i] & {psl_pkg::SLOT_W{match_oh[i]}});
      end
   end

   assign hit      = |match_oh;
   assign full     = &valid_ff;
   assign free_vec = ~valid_ff;
   assign free_oh  = free_vec & (-free_vec);

   assign insert_en = lookup_req.fire && (lookup_req.kind == psl_pkg::KIND_INSERT)
                      && !hit && !full;
   assign delete_en = lookup_req.fire && (lookup_req.kind == psl_pkg::KIND_DELETE) && hit;

   always_comb begin
      valid_in = valid_ff;
      priority if (insert_en) begin
         valid_in = valid_ff | free_oh;
      end else if (delete_en) begin
         valid_in = valid_ff & ~match_oh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < psl_pkg::TABLE_ENTRIES; i++) begin
         if (insert_en && free_oh[i]) begin
            key_ff[i]  <= lookup_req.key;
            slot_ff[i] <= lookup_req.slot;
         end
      end
   end

   assign lookup_rsp.hit  = hit;
   assign lookup_rsp.full = full;
   assign lookup_rsp.slot = hit_slot;

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_oh))
      else $error("key held in more than one entry");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      insert_en |=> $countones(valid_ff) == $past($countones(valid_ff)) + 1)
      else $error("insert did not add exactly one entry");

   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      delete_en |=> $countones(valid_ff) + 1 == $past($countones(valid_ff)))
      else $error("delete did not remove exactly one entry");

endmodule
